// ===== sv/ebma_pkg.sv =====
package ebma_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int SAMPLE_W      = 16;
    localparam int WEIGHT_W      = 17;
    localparam int WEIGHT_SHIFT  = 16;
    localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int TOTAL_W       = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int AVG_W         = SAMPLE_W + 1;
    localparam int RECIP_SHIFT   = TOTAL_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int WS_W          = WEIGHT_W + 1 + SAMPLE_W;
    localparam int IA_W          = WEIGHT_W + 1 + AVG_W;
    localparam int NUM_W         = IA_W + 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1 << WEIGHT_SHIFT);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1 << (WEIGHT_SHIFT - 1));
    localparam logic [RECIP_W-1:0]  RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam logic signed [TOTAL_W-1:0] DEPTH_S = TOTAL_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_INIT   = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic                       valid;
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [WS_W-1:0]     ws;
    } stage_t;

    typedef struct packed
    {
        logic [HISTORY_DEPTH-1:0][SAMPLE_W-1:0] hist;
        logic signed [TOTAL_W-1:0]              total;
        logic [PTR_W-1:0]                       ptr;
    } state_t;

    function automatic logic signed [TOTAL_W-1:0] hist_sum(
        input logic [HISTORY_DEPTH-1:0][SAMPLE_W-1:0] h
    );
        logic signed [TOTAL_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            acc = acc + TOTAL_W'($signed(h[i]));
        end
        return acc;
    endfunction

endpackage

// ===== sv/exp_blend_moving_average_filter_unit.sv =====
// channel  | handshake            | payload
// ---------+----------------------+------------------------
// input    | in_valid / in_stall  | kind, sample
// output   | out_valid / out_stall| filtered
// config   | cfg_valid / cfg_ready| blend_weight
//
// One word per cycle while the output is not stalled; each word passes the input register, then the result register.
// The blend, average and history update are combinational within the
// running-total feedback loop (reciprocal multiply, then blend multiply).
// Reset clears history, total and pointer to zero and weight to one half.
// An output stall holds the result register and backs up into the input
// register; in_stall rises only when that register is full and blocked.
module exp_blend_moving_average_filter_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic signed [ebma_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ebma_pkg::SAMPLE_W-1:0] filtered,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ebma_pkg::WEIGHT_W-1:0]        blend_weight
);

    logic [ebma_pkg::WEIGHT_W-1:0]        weight_reg;
    logic [ebma_pkg::WEIGHT_W-1:0]        weight_next;
    logic                                 out_v_reg;
    logic                                 out_v_next;
    logic signed [ebma_pkg::SAMPLE_W-1:0] out_d_reg;
    logic                                 out_free;
    logic                                 fire;
    ebma_pkg::stage_t                     stage;
    ebma_pkg::state_t                     state;
    logic signed [ebma_pkg::SAMPLE_W-1:0] result;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_v_reg || !out_stall;
    assign fire      = stage.valid && out_free;

    // clamp weight to one
    assign weight_next = (blend_weight > ebma_pkg::WEIGHT_ONE) ? ebma_pkg::WEIGHT_ONE
                                                               : blend_weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= ebma_pkg::WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            weight_reg <= weight_next;
        end
    end

    ebma_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .sample   (sample),
        .weight   (weight_reg),
        .take     (fire),
        .stage    (stage)
    );

    ebma_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .stage  (stage),
        .weight (weight_reg),
        .result (result),
        .state  (state)
    );

    always_comb
    begin
        out_v_next = out_v_reg;
        if (fire)
        begin
            out_v_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_d_reg <= result;
        end
    end

    assign out_valid = out_v_reg;
    assign filtered  = out_d_reg;

    a_total_matches_history: assert property (@(posedge clk) disable iff (!rst_n)
        state.total == ebma_pkg::hist_sum(state.hist))
        else $error("running total differs from history sum");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state.ptr <= ebma_pkg::PTR_LAST)
        else $error("oldest pointer out of range");

    a_init_resets_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage.kind == ebma_pkg::KIND_INIT |=>
            state.ptr == '0 && filtered == $past(stage.sample))
        else $error("init word did not rewind pointer or echo sample");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("computed word lost before output register");

endmodule

// ===== sv/ebma_in_stage.sv =====
module ebma_in_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [ebma_pkg::SAMPLE_W-1:0] sample,
    input  logic [ebma_pkg::WEIGHT_W-1:0]       weight,
    input  logic                                take,
    output ebma_pkg::stage_t                    stage
);

    logic                                  valid_reg;
    logic                                  valid_next;
    ebma_pkg::stage_t                      data_reg;
    logic                                  load;
    logic signed [ebma_pkg::WS_W-1:0]      ws;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;
    assign ws       = $signed({1'b0, weight}) * sample;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold payload until the next word is loaded
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.valid  <= 1'b1;
            data_reg.kind   <= ebma_pkg::kind_t'(kind);
            data_reg.sample <= sample;
            data_reg.ws     <= ws;
        end
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

// ===== sv/ebma_core.sv =====
module ebma_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  ebma_pkg::stage_t                     stage,
    input  logic [ebma_pkg::WEIGHT_W-1:0]        weight,
    output logic signed [ebma_pkg::SAMPLE_W-1:0] result,
    output ebma_pkg::state_t                     state
);

    ebma_pkg::state_t                                  state_reg;
    ebma_pkg::state_t                                  state_next;
    logic                                              neg;
    logic [ebma_pkg::TOTAL_W-1:0]                      mag;
    logic [ebma_pkg::TOTAL_W+ebma_pkg::RECIP_W-1:0]    quot_prod;
    logic [ebma_pkg::AVG_W-1:0]                        quot;
    logic signed [ebma_pkg::AVG_W-1:0]                 avg;
    logic [ebma_pkg::WEIGHT_W-1:0]                     inv_w;
    logic signed [ebma_pkg::IA_W-1:0]                  ia;
    logic signed [ebma_pkg::NUM_W-1:0]                 num;
    logic signed [ebma_pkg::SAMPLE_W-1:0]              blend;
    logic signed [ebma_pkg::SAMPLE_W-1:0]              oldest;

    always_comb
    begin
        neg       = state_reg.total[ebma_pkg::TOTAL_W-1];
        mag       = neg ? ebma_pkg::TOTAL_W'(-state_reg.total)
                        : ebma_pkg::TOTAL_W'(state_reg.total);
        quot_prod = ebma_pkg::TOTAL_W'(mag) * ebma_pkg::RECIP;
        quot      = quot_prod[ebma_pkg::RECIP_SHIFT +: ebma_pkg::AVG_W];
        avg       = neg ? -$signed(quot) : $signed(quot);
        inv_w     = ebma_pkg::WEIGHT_ONE - weight;
        ia        = $signed({1'b0, inv_w}) * avg;
        num       = ebma_pkg::NUM_W'(stage.ws) + ebma_pkg::NUM_W'(ia);
        blend     = num[ebma_pkg::WEIGHT_SHIFT +: ebma_pkg::SAMPLE_W];
        oldest    = $signed(state_reg.hist[state_reg.ptr]);
        result    = (stage.kind == ebma_pkg::KIND_INIT) ? stage.sample : blend;
    end

    always_comb
    begin
        state_next = state_reg;
        if (stage.kind == ebma_pkg::KIND_INIT)
        begin
            for (int i = 0; i < ebma_pkg::HISTORY_DEPTH; i++)
            begin
                state_next.hist[i] = stage.sample;
            end
            state_next.total = ebma_pkg::TOTAL_W'(
                ebma_pkg::TOTAL_W'(stage.sample) * ebma_pkg::DEPTH_S);
            state_next.ptr   = '0;
        end
        else
        begin
            state_next.hist[state_reg.ptr] = blend;
            state_next.total = state_reg.total + ebma_pkg::TOTAL_W'(blend)
                               - ebma_pkg::TOTAL_W'(oldest);
            state_next.ptr   = (state_reg.ptr == ebma_pkg::PTR_LAST) ? '0
                               : ebma_pkg::PTR_W'(state_reg.ptr + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule
